// ===== rtl/piecewise_linear_interpolator_top_assert.svh =====
// Assertion macros for the piecewise linear interpolator top level
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PLI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pli_pkg.sv =====
// Package: types, constants and register map of the piecewise linear interpolator
`timescale 1ns / 1ps

package pli_pkg;

    // Curve geometry
    localparam int MAX_SEGMENTS = 3;
    localparam int NUM_VALUES   = MAX_SEGMENTS + 1;

    // Default transaction queue depth between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Quotient bits produced by the serial divider, one per cycle
    localparam int DIV_STEPS = 16;

    // Register map (index = paddr[4:2])
    localparam logic [2:0] REG_SEGMENTS_IN_USE = 3'd0;
    localparam logic [2:0] REG_END_TIME_1      = 3'd1;
    localparam logic [2:0] REG_END_TIME_2      = 3'd2;
    localparam logic [2:0] REG_END_TIME_3      = 3'd3;
    localparam logic [2:0] REG_VALUE_0         = 3'd4;
    localparam logic [2:0] REG_VALUE_1         = 3'd5;
    localparam logic [2:0] REG_VALUE_2         = 3'd6;
    localparam logic [2:0] REG_VALUE_3         = 3'd7;

    // Register reset values
    localparam logic [1:0]  RST_SEGMENTS_IN_USE = 2'd3;
    localparam logic [15:0] RST_END_TIME_1      = 16'd100;
    localparam logic [15:0] RST_END_TIME_2      = 16'd200;
    localparam logic [15:0] RST_END_TIME_3      = 16'd300;
    localparam logic [15:0] RST_VALUE_0         = 16'd0;
    localparam logic [15:0] RST_VALUE_1         = 16'd256;
    localparam logic [15:0] RST_VALUE_2         = 16'd256;
    localparam logic [15:0] RST_VALUE_3         = 16'd256;

    // Result region codes
    typedef enum logic [1:0] {
        REGION_START  = 2'd0,
        REGION_INSIDE = 2'd1,
        REGION_END    = 2'd2
    } pli_region_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } pli_back_state_t;

    // Curve configuration as seen by the front end
    typedef struct packed {
        logic [1:0]                         segments_in_use;
        logic [MAX_SEGMENTS-1:0][15:0]      end_time;
        logic [NUM_VALUES-1:0][15:0]        value;
    } pli_cfg_t;

    // Classified transaction handed from front to back
    typedef struct packed {
        logic        direct;    // result is base, no interpolation
        pli_region_t region;
        logic [1:0]  seg;
        logic [15:0] base;      // start value, Q8.8 signed
        logic        diff_neg;  // sign of (stop - start)
        logic [15:0] diff_mag;  // |stop - start|
        logic [15:0] dt;        // t - t1
        logic [15:0] span;      // t2 - t1, non-zero when not direct
    } pli_item_t;

    // Back-end status for the top level
    typedef struct packed {
        logic idle;
        logic dividing;
    } pli_back_status_t;

endpackage

// ===== rtl/piecewise_linear_interpolator_top.sv =====
// Top level: APB register file, front end, transaction queue and back end
//
//  Channel   Handshake                       Payload
//  --------  ------------------------------  ----------------------------------
//  command   start (taken when busy is low)  time_offset
//  result    done, one-cycle strobe          curve_value, region, segment_index
//  config    APB psel/penable/pwrite/pready  paddr, pwdata, prdata
//
//  Each transaction passes through the back end as pop, multiply, 16 restoring divide
//  steps and output when interpolated, and as pop and output when the value is taken
//  directly; done follows the output cycle, so the divider sets the rate. The queue holds
//  QUEUE_DEPTH classified transactions, and busy is high while it is full. Results
//  cannot be stalled; done is high for one cycle.
//  Reset is asynchronous and active low and loads the default curve.
`timescale 1ns / 1ps

module piecewise_linear_interpolator_top
    import pli_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [16:0] time_offset,
    // result channel
    output logic        done,
    output logic [15:0] curve_value,
    output logic [1:0]  region,
    output logic [1:0]  segment_index,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "piecewise_linear_interpolator_top_assert.svh"

    logic [1:0]  segments_in_use_reg;
    logic [15:0] end_time_1_reg;
    logic [15:0] end_time_2_reg;
    logic [15:0] end_time_3_reg;
    logic [15:0] value_0_reg;
    logic [15:0] value_1_reg;
    logic [15:0] value_2_reg;
    logic [15:0] value_3_reg;

    logic [2:0]       reg_index;
    logic             cfg_write;
    pli_cfg_t         cfg;
    pli_item_t        front_item;
    pli_item_t        q_head;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    pli_back_status_t back_status;

    // APB register file
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segments_in_use_reg <= RST_SEGMENTS_IN_USE;
            end_time_1_reg      <= RST_END_TIME_1;
            end_time_2_reg      <= RST_END_TIME_2;
            end_time_3_reg      <= RST_END_TIME_3;
            value_0_reg         <= RST_VALUE_0;
            value_1_reg         <= RST_VALUE_1;
            value_2_reg         <= RST_VALUE_2;
            value_3_reg         <= RST_VALUE_3;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_SEGMENTS_IN_USE: segments_in_use_reg <= pwdata[1:0];
                REG_END_TIME_1:      end_time_1_reg      <= pwdata[15:0];
                REG_END_TIME_2:      end_time_2_reg      <= pwdata[15:0];
                REG_END_TIME_3:      end_time_3_reg      <= pwdata[15:0];
                REG_VALUE_0:         value_0_reg         <= pwdata[15:0];
                REG_VALUE_1:         value_1_reg         <= pwdata[15:0];
                REG_VALUE_2:         value_2_reg         <= pwdata[15:0];
                REG_VALUE_3:         value_3_reg         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        prdata = 32'd0;
        unique case (reg_index)
            REG_SEGMENTS_IN_USE: prdata = {30'd0, segments_in_use_reg};
            REG_END_TIME_1:      prdata = {16'd0, end_time_1_reg};
            REG_END_TIME_2:      prdata = {16'd0, end_time_2_reg};
            REG_END_TIME_3:      prdata = {16'd0, end_time_3_reg};
            REG_VALUE_0:         prdata = {16'd0, value_0_reg};
            REG_VALUE_1:         prdata = {16'd0, value_1_reg};
            REG_VALUE_2:         prdata = {16'd0, value_2_reg};
            REG_VALUE_3:         prdata = {16'd0, value_3_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Curve configuration bundle
    assign cfg.segments_in_use = segments_in_use_reg;
    assign cfg.end_time        = {end_time_3_reg, end_time_2_reg, end_time_1_reg};
    assign cfg.value           = {value_3_reg, value_2_reg, value_1_reg, value_0_reg};

    // Command acceptance
    assign busy   = q_full;
    assign q_push = start && !busy;

    pli_front u_front
    (
        .cfg         (cfg),
        .time_offset (time_offset),
        .item        (front_item)
    );

    pli_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    pli_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .status        (back_status),
        .done          (done),
        .curve_value   (curve_value),
        .region        (region),
        .segment_index (segment_index)
    );

    // Checks
    `PLI_ASSERT_NOW(a_seg_zero_outside, done && (region != REGION_INSIDE), segment_index == 2'd0, "segment_index set outside a segment")
    `PLI_ASSERT_NEXT(a_no_spurious_done, back_status.idle && q_empty, !done, "result without a queued transaction")
    `PLI_ASSERT_NEXT(a_push_kept, q_push, !q_empty, "accepted transaction lost from queue")
    `PLI_ASSERT_NOW(a_no_pop_while_dividing, back_status.dividing, !q_pop, "queue popped during divide")

endmodule

// ===== rtl/pli_front.sv =====
// Front end: classifies a time offset against the curve and builds a transaction
`timescale 1ns / 1ps

module pli_front
    import pli_pkg::*;
(
    input  pli_cfg_t    cfg,
    input  logic [16:0] time_offset,
    output pli_item_t   item
);

    logic [1:0]  n_seg;
    logic [1:0]  last_idx;
    logic [15:0] last_end;
    logic        past_end;
    logic        positive;
    logic [15:0] t_u;
    logic        found;
    logic [1:0]  hit_seg;
    logic [15:0] hit_t1;
    logic [15:0] seg_t1;
    logic [15:0] start_val;
    logic [15:0] stop_val;
    logic [16:0] diff;
    logic [15:0] span;

    // Segment count clamped to 1..MAX_SEGMENTS
    always_comb
    begin
        if (cfg.segments_in_use == 2'd0)
            n_seg = 2'd1;
        else if (32'(cfg.segments_in_use) > MAX_SEGMENTS)
            n_seg = 2'(MAX_SEGMENTS);
        else
            n_seg = cfg.segments_in_use;
        last_idx = n_seg - 2'd1;
        last_end = cfg.end_time[last_idx];
    end

    // Past-end and positive-time tests
    assign past_end = $signed({time_offset[16], time_offset}) >= $signed({2'b00, last_end});
    assign positive = !time_offset[16] && (time_offset != 17'd0);
    assign t_u      = time_offset[15:0];

    // First segment whose span holds t
    always_comb
    begin
        found   = 1'b0;
        hit_seg = 2'd0;
        hit_t1  = 16'd0;
        seg_t1  = 16'd0;
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            if (!found && (i < 32'(n_seg)) && (seg_t1 <= t_u) && (t_u <= cfg.end_time[i]))
            begin
                found   = 1'b1;
                hit_seg = 2'(i);
                hit_t1  = seg_t1;
            end
            seg_t1 = cfg.end_time[i];
        end
    end

    // Segment endpoints
    assign start_val = cfg.value[hit_seg];
    assign stop_val  = cfg.value[hit_seg + 2'd1];
    assign diff      = {stop_val[15], stop_val} - {start_val[15], start_val};
    assign span      = cfg.end_time[hit_seg] - hit_t1;

    // Transaction build
    always_comb
    begin
        item.direct   = 1'b1;
        item.region   = REGION_START;
        item.seg      = 2'd0;
        item.base     = cfg.value[0];
        item.diff_neg = diff[16];
        item.diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
        item.dt       = t_u - hit_t1;
        item.span     = span;
        priority if (past_end)
        begin
            item.region = REGION_END;
            item.base   = cfg.value[n_seg];
        end
        else if (positive && found)
        begin
            item.region = REGION_INSIDE;
            item.seg    = hit_seg;
            item.base   = start_val;
            item.direct = (span == 16'd0);
        end
    end

endmodule

// ===== rtl/pli_queue.sv =====
// Short transaction queue between the front and back ends
`timescale 1ns / 1ps

module pli_queue
    import pli_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pli_item_t push_item,
    input  logic      pop,
    output pli_item_t head,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pli_item_t        store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/pli_back.sv =====
// Back end: multiply, serial restoring divide and result output
`timescale 1ns / 1ps

module pli_back
    import pli_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  pli_item_t        q_head,
    output logic             q_pop,
    output pli_back_status_t status,
    output logic             done,
    output logic [15:0]      curve_value,
    output logic [1:0]       region,
    output logic [1:0]       segment_index
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    pli_back_state_t state_reg, state_next;
    pli_item_t       item_reg;
    logic [15:0]     rem_reg;
    logic [15:0]     quo_reg;   // low dividend bits, shifted out as quotient comes in
    logic [CNT_W-1:0] cnt_reg;
    logic            done_reg;
    logic [15:0]     value_reg;
    logic [1:0]      region_reg;
    logic [1:0]      seg_reg;

    logic            load_item;
    logic            load_prod;
    logic            div_step;
    logic            emit;
    logic [31:0]     product;
    logic [16:0]     trial;
    logic            q_bit;
    logic [16:0]     q_signed;
    logic [16:0]     sum;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                    state_next = q_head.direct ? BK_DONE : BK_MUL;
            end
            BK_MUL:
                state_next = BK_DIV;
            BK_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = BK_DONE;
            end
            BK_DONE:
                state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        load_item = 1'b0;
        load_prod = 1'b0;
        div_step  = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            BK_IDLE: load_item = !q_empty;
            BK_MUL:  load_prod = 1'b1;
            BK_DIV:  div_step  = 1'b1;
            BK_DONE: emit      = 1'b1;
            default: ;
        endcase
    end

    assign q_pop           = load_item;
    assign status.idle     = (state_reg == BK_IDLE);
    assign status.dividing = (state_reg == BK_DIV);

    // Datapath: |diff| * dt, then one quotient bit per cycle
    assign product = item_reg.diff_mag * item_reg.dt;
    assign trial   = {rem_reg, quo_reg[15]};
    assign q_bit   = (trial >= {1'b0, item_reg.span});

    // Quotient carries the sign of the value step; magnitude division truncates toward zero
    assign q_signed = item_reg.diff_neg ? 17'(-{1'b0, quo_reg}) : {1'b0, quo_reg};
    assign sum      = item_reg.direct ? {item_reg.base[15], item_reg.base}
                                      : {item_reg.base[15], item_reg.base} + q_signed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit;
            if (load_prod)
                cnt_reg <= '0;
            else if (div_step)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load_item)
            item_reg <= q_head;
        if (load_prod)
        begin
            rem_reg <= product[31:16];
            quo_reg <= product[15:0];
        end
        else if (div_step)
        begin
            rem_reg <= q_bit ? 16'(trial - {1'b0, item_reg.span}) : trial[15:0];
            quo_reg <= {quo_reg[14:0], q_bit};
        end
        if (emit)
        begin
            value_reg  <= sum[15:0];
            region_reg <= item_reg.region;
            seg_reg    <= item_reg.seg;
        end
    end

    assign done          = done_reg;
    assign curve_value   = value_reg;
    assign region        = region_reg;
    assign segment_index = seg_reg;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the piecewise linear interpolator top level
`timescale 1ns / 1ps

module tb;
    import pli_pkg::*;

    localparam int ITEMS_PER_PHASE = 206;
    localparam int CURVE_PHASES    = 8;
    // margin for the back end to finish a transaction, plus queue slack
    localparam int SETTLE_CYCLES   = 30;

    // One curve lookup result
    typedef struct {
        logic [15:0] value;
        pli_region_t region;
        logic [1:0]  seg;
    } curve_point_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    // Directed stimulus row: a lookup or a register write
    typedef struct {
        row_kind_t   kind;
        logic [2:0]  reg_idx;      // write rows only
        logic [16:0] arg;          // time offset, or register data
        bit          typed;        // expectation given in the row
        logic [15:0] want_value;
        pli_region_t want_region;
        logic [1:0]  want_seg;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [16:0] time_offset;
    logic        done;
    logic [15:0] curve_value;
    logic [1:0]  region;
    logic [1:0]  segment_index;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the curve registers
    logic [1:0]  seg_count;
    logic [15:0] end_time_cfg [MAX_SEGMENTS];
    logic [15:0] value_cfg [NUM_VALUES];

    curve_point_t pending_points [$];
    int           mismatch_count = 0;
    bit           line_open = 1'b0;

    // Reset curve: segments end at 100/200/300, values 0, 256, 256, 256
    stim_row_t directed_rows [41] = '{
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'h00000, 1'b1, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'h18000, 1'b1, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'h1FFFF, 1'b1, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'h0FFFF, 1'b1, 16'h0100, REGION_END,    2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd300,   1'b1, 16'h0100, REGION_END,    2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd50,    1'b1, 16'h0080, REGION_INSIDE, 2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd100,   1'b1, 16'h0100, REGION_INSIDE, 2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd1,     1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd150,   1'b1, 16'h0100, REGION_INSIDE, 2'd1},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd299,   1'b0, 16'h0000, REGION_START,  2'd0},
        // segment count of zero behaves as one
        '{ROW_WRITE, REG_SEGMENTS_IN_USE, 17'd0,     1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd100,   1'b1, 16'h0100, REGION_END,    2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd99,    1'b0, 16'h0000, REGION_START,  2'd0},
        // falling slope, quotient truncated toward zero
        '{ROW_WRITE, REG_SEGMENTS_IN_USE, 17'd3,     1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_WRITE, REG_VALUE_1,         17'hFF00,  1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd1,     1'b0, 16'h0000, REGION_START,  2'd0},
        // full-scale swing over the longest span
        '{ROW_WRITE, REG_SEGMENTS_IN_USE, 17'd1,     1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_WRITE, REG_END_TIME_1,      17'hFFFF,  1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_WRITE, REG_VALUE_0,         17'h8000,  1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_WRITE, REG_VALUE_1,         17'h7FFF,  1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd65534, 1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd32767, 1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'h0FFFF, 1'b1, 16'h7FFF, REGION_END,    2'd0},
        // last end time of zero: past-end test wins at time zero
        '{ROW_WRITE, REG_END_TIME_1,      17'd0,     1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd0,     1'b1, 16'h7FFF, REGION_END,    2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'h18000, 1'b1, 16'h8000, REGION_START,  2'd0},
        // equal end times, zero-length segments
        '{ROW_WRITE, REG_END_TIME_1,      17'd100,   1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_WRITE, REG_END_TIME_2,      17'd100,   1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_WRITE, REG_END_TIME_3,      17'd100,   1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_WRITE, REG_SEGMENTS_IN_USE, 17'd3,     1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd100,   1'b1, 16'h0100, REGION_END,    2'd0},
        '{ROW_WRITE, REG_END_TIME_3,      17'd200,   1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd100,   1'b1, 16'h7FFF, REGION_INSIDE, 2'd0},
        // decreasing end times
        '{ROW_WRITE, REG_END_TIME_1,      17'd150,   1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_WRITE, REG_END_TIME_2,      17'd50,    1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd160,   1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd120,   1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_WRITE, REG_VALUE_2,         17'h8000,  1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_WRITE, REG_VALUE_3,         17'h7FFF,  1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd199,   1'b0, 16'h0000, REGION_START,  2'd0},
        '{ROW_ITEM,  REG_SEGMENTS_IN_USE, 17'd51,    1'b0, 16'h0000, REGION_START,  2'd0}
    };

    piecewise_linear_interpolator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .time_offset   (time_offset),
        .done          (done),
        .curve_value   (curve_value),
        .region        (region),
        .segment_index (segment_index),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Curve value at one time offset, from the shadow registers
    function automatic curve_point_t interpolate(input logic [16:0] t_raw);
        curve_point_t pt;
        longint       t;
        longint       t1;
        longint       t2;
        longint       lo;
        longint       hi;
        longint       span;
        int           n;
        bit           found;
        t     = longint'($signed(t_raw));
        n     = int'(seg_count);
        if (n < 1)
            n = 1;
        if (n > MAX_SEGMENTS)
            n = MAX_SEGMENTS;
        pt.value  = value_cfg[0];
        pt.region = REGION_START;
        pt.seg    = 2'd0;
        t1        = 0;
        found     = 1'b0;
        // past-end test takes priority over the start test
        if (t >= longint'(end_time_cfg[n-1]))
        begin
            pt.value  = value_cfg[n];
            pt.region = REGION_END;
        end
        else if (t > 0)
        begin
            for (int i = 0; i < n && !found; i++)
            begin
                t2 = longint'(end_time_cfg[i]);
                if (t1 <= t && t <= t2)
                begin
                    lo   = longint'($signed(value_cfg[i]));
                    hi   = longint'($signed(value_cfg[i+1]));
                    span = t2 - t1;
                    // exact product, division truncates toward zero
                    pt.value  = (span > 0) ? 16'(lo + ((hi - lo) * (t - t1)) / span)
                                           : value_cfg[i];
                    pt.region = REGION_INSIDE;
                    pt.seg    = 2'(i);
                    found     = 1'b1;
                end
                t1 = t2;
            end
        end
        return pt;
    endfunction

    // Offer one lookup and hold it until the block takes it
    task automatic send_time(input logic [16:0] t, input bit typed,
                             input logic [15:0] want_value, input pli_region_t want_region,
                             input logic [1:0] want_seg);
        curve_point_t want;
        start       <= 1'b1;
        time_offset <= t;
        line_open    = 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (typed)
        begin
            want.value  = want_value;
            want.region = want_region;
            want.seg    = want_seg;
            pending_points.push_back(want);
        end
        else
            pending_points.push_back(interpolate(t));
    endtask

    // Drop start; junk on the payload while idle
    task automatic idle_line();
        if (line_open)
        begin
            start       <= 1'b0;
            time_offset <= 17'($urandom);
            line_open    = 1'b0;
        end
    endtask

    // Wait for every outstanding result, then let the pipeline empty
    task automatic settle();
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write, shadow update and read-back check
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        logic [31:0] word;
        logic [31:0] mask;
        word       = $urandom;
        word[15:0] = data;
        mask       = (idx == REG_SEGMENTS_IN_USE) ? 32'h0000_0003 : 32'h0000_FFFF;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SEGMENTS_IN_USE: seg_count       = word[1:0];
            REG_END_TIME_1:      end_time_cfg[0] = word[15:0];
            REG_END_TIME_2:      end_time_cfg[1] = word[15:0];
            REG_END_TIME_3:      end_time_cfg[2] = word[15:0];
            REG_VALUE_0:         value_cfg[0]    = word[15:0];
            REG_VALUE_1:         value_cfg[1]    = word[15:0];
            REG_VALUE_2:         value_cfg[2]    = word[15:0];
            REG_VALUE_3:         value_cfg[3]    = word[15:0];
            default: ;
        endcase
        // read back
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) !== (word & mask))
        begin
            $error("prdata[reg %0d]: expected %h, got %h", idx, word & mask, prdata & mask);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result checker: the receiver never stalls, so every strobe is a transaction
    always @(posedge clk)
    begin : check_results
        curve_point_t want;
        if (rst_n && done)
        begin
            if (pending_points.size() == 0)
            begin
                $error("result with none expected: curve_value %h region %0d segment_index %0d",
                       curve_value, region, segment_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (curve_value !== want.value)
                begin
                    $error("curve_value: expected %h, got %h", want.value, curve_value);
                    mismatch_count++;
                end
                if (region !== want.region)
                begin
                    $error("region: expected %0d, got %0d", want.region, region);
                    mismatch_count++;
                end
                if (segment_index !== want.seg)
                begin
                    $error("segment_index: expected %0d, got %0d", want.seg, segment_index);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [1:0]  segs;
        logic [15:0] ends [MAX_SEGMENTS];
        logic [15:0] vals [NUM_VALUES];
        logic [15:0] tmp;
        int          tv;
        int          sent;
        int          burst;
        int          gap_pick;

        rst_n       = 1'b0;
        start       = 1'b0;
        time_offset = 17'd0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 5'd0;
        pwdata      = 32'd0;

        seg_count       = RST_SEGMENTS_IN_USE;
        end_time_cfg[0] = RST_END_TIME_1;
        end_time_cfg[1] = RST_END_TIME_2;
        end_time_cfg[2] = RST_END_TIME_3;
        value_cfg[0]    = RST_VALUE_0;
        value_cfg[1]    = RST_VALUE_1;
        value_cfg[2]    = RST_VALUE_2;
        value_cfg[3]    = RST_VALUE_3;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                idle_line();
                settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].arg[15:0]);
            end
            else
                send_time(directed_rows[i].arg, directed_rows[i].typed,
                          directed_rows[i].want_value, directed_rows[i].want_region,
                          directed_rows[i].want_seg);
        end

        // Random part, one curve per phase
        for (int phase = 0; phase < CURVE_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                // widest times, full-scale values
                segs = 2'd3;
                ends = '{16'hFFFD, 16'hFFFE, 16'hFFFF};
                vals = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
            end
            else if (phase == 1)
            begin
                // degenerate curve: zero count, all end times zero
                segs = 2'd0;
                ends = '{16'h0000, 16'h0000, 16'h0000};
                vals = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
            end
            else
            begin
                segs = 2'($urandom_range(0, 3));
                foreach (vals[k])
                    vals[k] = 16'($urandom);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        // short ascending segments
                        ends[0] = 16'($urandom_range(0, 120));
                        ends[1] = ends[0] + 16'($urandom_range(0, 120));
                        ends[2] = ends[1] + 16'($urandom_range(0, 120));
                    end
                    1, 2:
                    begin
                        foreach (ends[k])
                            ends[k] = 16'($urandom);
                        for (int a = 0; a < MAX_SEGMENTS - 1; a++)
                            for (int b = 0; b < MAX_SEGMENTS - 1 - a; b++)
                                if (ends[b] > ends[b+1])
                                begin
                                    tmp       = ends[b];
                                    ends[b]   = ends[b+1];
                                    ends[b+1] = tmp;
                                end
                        if ($urandom_range(0, 1) == 0)
                            ends[1] = ends[0];
                    end
                    default:
                        // unordered end times
                        foreach (ends[k])
                            ends[k] = 16'($urandom);
                endcase
            end

            idle_line();
            settle();
            write_reg(REG_SEGMENTS_IN_USE, {14'd0, segs});
            write_reg(REG_END_TIME_1, ends[0]);
            write_reg(REG_END_TIME_2, ends[1]);
            write_reg(REG_END_TIME_3, ends[2]);
            write_reg(REG_VALUE_0, vals[0]);
            write_reg(REG_VALUE_1, vals[1]);
            write_reg(REG_VALUE_2, vals[2]);
            write_reg(REG_VALUE_3, vals[3]);

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++)
                begin
                    case ($urandom_range(0, 9))
                        0:       tv = int'($urandom_range(0, 98303)) - 32768;
                        1:       tv = -int'($urandom_range(1, 300));
                        2, 3:    tv = int'(end_time_cfg[$urandom_range(0, MAX_SEGMENTS - 1)])
                                      + int'($urandom_range(0, 4)) - 2;
                        default: tv = int'($urandom_range(0,
                                      int'(end_time_cfg[$urandom_range(0, MAX_SEGMENTS - 1)]) + 2));
                    endcase
                    if (tv > 65535)
                        tv = 65535;
                    if (tv < -32768)
                        tv = -32768;
                    send_time(17'(tv), 1'b0, 16'h0000, REGION_START, 2'd0);
                    sent++;
                end
                // between bursts: stream on, short gap, or full drain
                gap_pick = $urandom_range(0, 19);
                if (gap_pick >= 6)
                    idle_line();
                if (gap_pick == 19)
                    settle();
                else if (gap_pick >= 6)
                    repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end

        idle_line();
        settle();
        if (mismatch_count == 0)
            $display("[piecewise_linear_interpolator_top] OK");
        else
            $display("[piecewise_linear_interpolator_top] ERROR");
        $finish;
    end

    // Run limit
    initial
    begin
        #1_200_000;
        $display("[piecewise_linear_interpolator_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pli_pkg.sv
rtl/pli_front.sv
rtl/pli_queue.sv
rtl/pli_back.sv
rtl/piecewise_linear_interpolator_top.sv
verif/tb.sv
